>>> sv/quadrature_counter_with_speed_macros.svh
// assertion macros for the quadrature counter checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef QUADRATURE_COUNTER_WITH_SPEED_MACROS_SVH
`define QUADRATURE_COUNTER_WITH_SPEED_MACROS_SVH

// same-cycle implication
`define QCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quadrature counter: check failed");

// next-cycle implication
`define QCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quadrature counter: check failed");

`endif

>>> sv/qcs_pkg.sv
// shared types, constants and the transition table of the quadrature counter
// no dependencies
package qcs_pkg;

  // position counter width
  localparam int CountW = 32;
  // magnitudes above 2^40 always saturate, so the multiplier never needs more
  localparam int MagW   = (CountW < 41) ? CountW : 41;
  localparam int MpcW   = 24;
  localparam int ProdW  = MagW + MpcW;
  // product times 1000 fits in ten more bits
  localparam int NumW   = ProdW + 10;
  localparam int QuoW   = 32;
  localparam int HiW    = NumW - QuoW;
  // divisor is 256 times an elapsed time of at most 100 ms
  localparam int DenW   = 15;
  localparam int CntW   = $clog2(QuoW);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam logic [63:0] MagClamp     = 64'h0000_0100_0000_0000;
  localparam logic [31:0] MaxElapsedMs = 32'd100;
  localparam logic [15:0] PeriodReset  = 16'd10;

  // request codes
  localparam logic [1:0] ReqPin    = 2'd0;
  localparam logic [1:0] ReqSample = 2'd1;
  localparam logic [1:0] ReqStart  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSamplePeriod   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMetresPerCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCountDirection = 2'd2;

  // transition classes
  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirFwd  = 2'd1;
  localparam logic [1:0] DirRev  = 2'd2;

  typedef struct packed {
    logic load_item;
    logic mul;
    logic scale;
    logic div_step;
    logic fin;
    logic commit;
  } qcs_cmd_t;

  typedef struct packed {
    logic meas;
    logic div_last;
    logic out_free;
  } qcs_status_t;

  // classify a pin transition, pins packed as {a, b}
  function automatic logic [1:0] qcs_trans(input logic [1:0] prev, input logic [1:0] cur);
    logic [1:0] res;
    res = DirNone;
    case ({prev, cur})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: res = DirFwd;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: res = DirRev;
      default: res = DirNone;
    endcase
    return res;
  endfunction

endpackage

>>> sv/qcs_if.sv
// request and result channel interfaces of the quadrature counter
// depends on nothing but the field widths
interface qcs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        pin_a;
  logic        pin_b;
  logic [31:0] now_ms;

  modport source (output valid, output req_type, output pin_a, output pin_b,
                  output now_ms, input ready);
  modport sink   (input valid, input req_type, input pin_a, input pin_b,
                  input now_ms, output ready);
endinterface

interface qcs_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] speed;
  logic               speed_valid;
  logic               sample_taken;

  modport source (output valid, output position, output speed, output speed_valid,
                  output sample_taken, input ready);
  modport sink   (input valid, input position, input speed, input speed_valid,
                  input sample_taken, output ready);
endinterface

>>> sv/qcs_ctrl.sv
// sequencer of the quadrature counter: steps the datapath through one word
// depends on qcs_pkg
module qcs_ctrl import qcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  qcs_status_t status_i,
  output qcs_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = status_i.meas ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/qcs_datapath.sv
// datapath of the quadrature counter: config, counter state, speed multiply
// and restoring divide, output register; depends on qcs_pkg
module qcs_datapath import qcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [1:0]          in_req_type_i,
  input  logic                in_pin_a_i,
  input  logic                in_pin_b_i,
  input  logic [31:0]         in_now_ms_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output logic signed [31:0]  res_position_o,
  output logic signed [31:0]  res_speed_o,
  output logic                res_speed_valid_o,
  output logic                res_sample_taken_o,
  input  qcs_cmd_t            cmd_i,
  output qcs_status_t         status_o
);

  // configuration
  logic [15:0]     period_q;
  logic [MpcW-1:0] mpc_q;
  logic            dir_q;

  // accepted word
  logic [1:0]  req_q;
  logic [1:0]  cur_q;
  logic [31:0] now_q;

  // counter state
  logic [1:0]        prev_q, prev_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] lcnt_q, lcnt_d;
  logic [31:0]       ltime_q, ltime_d;
  logic [31:0]       spd_q, spd_d;
  logic              ok_q, ok_d;

  // speed arithmetic
  logic [ProdW-1:0] prod_q, prod_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [DenW-1:0]  rem_q;
  logic [QuoW-1:0]  lo_q;
  logic             neg_q, sat_q;
  logic [31:0]      speed_res_q;
  logic [CntW-1:0]  cnt_q;

  // output register
  logic               res_valid_q;
  logic signed [31:0] res_pos_q, res_spd_q;
  logic               res_ok_q, res_taken_q;

  logic [31:0]       elapsed;
  logic [15:0]       period_eff;
  logic              take, meas;
  logic [CountW-1:0] diff, mag_full;
  logic              neg;
  logic              clamp;
  logic [MagW-1:0]   mag_c;
  logic [NumW-1:0]   num;
  logic [HiW-1:0]    hi;
  logic [DenW:0]     trial, trial_sub;
  logic              ge;
  logic [31:0]       limit, mag_res;
  logic [1:0]        trans;
  logic              step_up, step_dn;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      mpc_q    <= '0;
      dir_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSamplePeriod:   period_q <= cfg_wdata_i[15:0];
        CfgMetresPerCount: mpc_q    <= cfg_wdata_i[MpcW-1:0];
        CfgCountDirection: dir_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      req_q <= in_req_type_i;
      cur_q <= {in_pin_a_i, in_pin_b_i};
      now_q <= in_now_ms_i;
    end
  end

  // sample decision
  assign elapsed    = now_q - ltime_q;
  assign period_eff = (period_q == '0) ? 16'd1 : period_q;
  assign take       = (req_q == ReqSample) && (elapsed >= {16'b0, period_eff});
  assign meas       = take && (mpc_q != '0) && (elapsed <= MaxElapsedMs);

  // count delta as sign and magnitude
  assign diff     = pos_q - lcnt_q;
  assign neg      = diff[CountW-1];
  assign mag_full = neg ? (CountW'(0) - diff) : diff;
  assign clamp    = 64'(mag_full) > MagClamp;
  assign mag_c    = clamp ? MagW'(MagClamp + 64'd1) : MagW'(mag_full);
  assign prod_d   = mag_c * mpc_q;
  assign den_d    = {elapsed[6:0], 8'b0};

  // times 1000 as 1024 - 16 - 8
  assign num = (NumW'(prod_q) << 10) - (NumW'(prod_q) << 4) - (NumW'(prod_q) << 3);
  assign hi  = num[NumW-1:QuoW];

  // one quotient bit per cycle
  assign trial     = {rem_q, lo_q[QuoW-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  assign limit   = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mag_res = (sat_q || (lo_q > limit)) ? limit : lo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      den_q  <= den_d;
      neg_q  <= neg;
    end
    if (cmd_i.scale) begin
      // a quotient of 2^32 or more saturates
      sat_q <= hi >= HiW'(den_q);
      rem_q <= hi[DenW-1:0];
      lo_q  <= num[QuoW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial_sub[DenW-1:0] : trial[DenW-1:0];
      lo_q  <= {lo_q[QuoW-2:0], ge};
    end
    if (cmd_i.fin) begin
      speed_res_q <= neg_q ? (32'd0 - mag_res) : mag_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.scale) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // next counter state
  assign trans   = qcs_trans(prev_q, cur_q);
  assign step_up = dir_q ? (trans == DirRev) : (trans == DirFwd);
  assign step_dn = dir_q ? (trans == DirFwd) : (trans == DirRev);

  always_comb begin
    prev_d  = prev_q;
    pos_d   = pos_q;
    lcnt_d  = lcnt_q;
    ltime_d = ltime_q;
    spd_d   = spd_q;
    ok_d    = ok_q;
    case (req_q)
      ReqPin: begin
        prev_d = cur_q;
        if (step_up) begin
          pos_d = pos_q + CountW'(1);
        end else if (step_dn) begin
          pos_d = pos_q - CountW'(1);
        end
      end
      ReqSample: begin
        if (take) begin
          spd_d   = meas ? speed_res_q : 32'd0;
          ok_d    = meas;
          lcnt_d  = pos_q;
          ltime_d = now_q;
        end
      end
      ReqStart: begin
        prev_d  = cur_q;
        ltime_d = now_q;
        spd_d   = 32'd0;
        ok_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pos_q   <= '0;
      lcnt_q  <= '0;
      ltime_q <= '0;
      spd_q   <= '0;
      ok_q    <= 1'b0;
    end else if (cmd_i.commit) begin
      prev_q  <= prev_d;
      pos_q   <= pos_d;
      lcnt_q  <= lcnt_d;
      ltime_q <= ltime_d;
      spd_q   <= spd_d;
      ok_q    <= ok_d;
    end
  end

  assign out_free = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_pos_q   <= 32'(pos_d);
      res_spd_q   <= ok_d ? spd_d : 32'd0;
      res_ok_q    <= ok_d;
      res_taken_q <= take;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign res_position_o     = res_pos_q;
  assign res_speed_o        = res_spd_q;
  assign res_speed_valid_o  = res_ok_q;
  assign res_sample_taken_o = res_taken_q;

  assign status_o.meas     = meas;
  assign status_o.div_last = (cnt_q == {CntW{1'b1}});
  assign status_o.out_free = out_free;

endmodule

>>> sv/quadrature_counter_with_speed.sv
// channel  dir  handshake     payload
// req_i    in   valid/ready   req_type, pin_a, pin_b, now_ms
// res_o    out  valid/ready   position, speed, speed_valid, sample_taken
// cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// one word at a time: pin, start and non-measuring words pass from accept through
// an evaluate state to the commit; a speed sample adds one multiply, one scale
// step, 32 steps of the restoring divider and one saturate step
// rst_ni clears the counter state and loads the register defaults at once
// a result waits in the output register; the next word is taken meanwhile
// and only its commit stalls until the register frees
// top level of the quadrature counter; depends on qcs_pkg, qcs_if, qcs_ctrl
// and qcs_datapath
module quadrature_counter_with_speed import qcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  qcs_req_if.sink             req_i,
  qcs_res_if.source           res_o
);

  qcs_cmd_t    cmd;
  qcs_status_t status;
  logic        in_ready;

  assign req_i.ready = in_ready;

  qcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qcs_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_req_type_i      (req_i.req_type),
    .in_pin_a_i         (req_i.pin_a),
    .in_pin_b_i         (req_i.pin_b),
    .in_now_ms_i        (req_i.now_ms),
    .res_ready_i        (res_o.ready),
    .res_valid_o        (res_o.valid),
    .res_position_o     (res_o.position),
    .res_speed_o        (res_o.speed),
    .res_speed_valid_o  (res_o.speed_valid),
    .res_sample_taken_o (res_o.sample_taken),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule

>>> sv/qcs_checker.sv
// port-level checks of the quadrature counter and the bind that attaches them
// depends on quadrature_counter_with_speed_macros.svh
`include "quadrature_counter_with_speed_macros.svh"

module qcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] position_i,
  input logic [31:0] speed_i,
  input logic        speed_valid_i,
  input logic        sample_taken_i
);

  // an invalid measurement always reads as zero speed
  `QCS_ASSERT_IMP(a_speed_zero_when_invalid, out_valid_i && !speed_valid_i, speed_i == 32'd0)

  // one word in flight: ready drops after an accept
  `QCS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // a new result only follows a busy cycle
  `QCS_ASSERT_IMP(a_result_after_work, $rose(out_valid_i), $past(!in_ready_i))

  // stalled result word holds
  `QCS_ASSERT_NXT(a_result_holds, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(position_i) && $stable(speed_i) &&
                  $stable(speed_valid_i) && $stable(sample_taken_i))

endmodule

bind quadrature_counter_with_speed qcs_checker u_qcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .position_i     (res_o.position),
  .speed_i        (res_o.speed),
  .speed_valid_i  (res_o.speed_valid),
  .sample_taken_i (res_o.sample_taken)
);

>>> bench/testbench.sv
// testbench of the quadrature counter with speed measurement: drives pin, sample
// and start words, predicts every result and checks it field by field
// depends on qcs_pkg, qcs_if and quadrature_counter_with_speed
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]  req_type;
  logic        pin_a;
  logic        pin_b;
  logic [31:0] now_ms;
} enc_word_t;

typedef struct packed {
  logic signed [31:0] position;
  logic signed [31:0] speed;
  logic               speed_valid;
  logic               sample_taken;
} enc_reading_t;

// tracks encoder position and measured speed, holds the readings still due
class speed_tracker;
  logic [15:0]  period_ms;
  logic [23:0]  metres_per_cnt;
  logic         count_rev;
  logic [1:0]   last_pins;
  logic [31:0]  count;
  logic [31:0]  ref_count;
  logic [31:0]  ref_time;
  logic [31:0]  speed_q;
  logic         speed_good;
  enc_reading_t due_readings[$];
  int unsigned  errors;

  function new();
    period_ms      = qcs_pkg::PeriodReset;
    metres_per_cnt = '0;
    count_rev      = 1'b0;
    last_pins      = '0;
    count          = '0;
    ref_count      = '0;
    ref_time       = '0;
    speed_q        = '0;
    speed_good     = 1'b0;
    errors         = 0;
  endfunction

  function void write_reg(input logic [1:0] idx, input logic [23:0] data);
    case (idx)
      qcs_pkg::CfgSamplePeriod:   period_ms      = data[15:0];
      qcs_pkg::CfgMetresPerCount: metres_per_cnt = data;
      qcs_pkg::CfgCountDirection: count_rev      = data[0];
      default: ;
    endcase
  endfunction

  // q16.16 m/s from count delta, truncated toward zero and saturated
  function logic [31:0] speed_of(input logic [31:0] elapsed);
    logic [31:0] diff;
    logic        neg;
    logic [63:0] mag, lim, num, den, q, r, res;
    diff = count - ref_count;
    neg  = diff[31];
    mag  = neg ? {32'd0, -diff} : {32'd0, diff};
    lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    num  = mag * {40'd0, metres_per_cnt};
    den  = 64'd256 * {32'd0, elapsed};
    q    = num / den;
    r    = num % den;
    if (q > 64'd2147484) res = lim;
    else res = q * 64'd1000 + (r * 64'd1000) / den;
    if (res > lim) res = lim;
    return neg ? -res[31:0] : res[31:0];
  endfunction

  function void take_word(input enc_word_t w);
    logic [1:0]   pins;
    int           step;
    logic [31:0]  elapsed, period;
    logic         taken;
    enc_reading_t exp;
    pins  = {w.pin_a, w.pin_b};
    taken = 1'b0;
    step  = 0;
    case (w.req_type)
      qcs_pkg::ReqPin: begin
        case ({last_pins, pins})
          4'b0001, 4'b0111, 4'b1110, 4'b1000: step = 1;
          4'b0010, 4'b1011, 4'b1101, 4'b0100: step = -1;
          default: step = 0;
        endcase
        if (count_rev) step = -step;
        if (step > 0) count = count + 32'd1;
        else if (step < 0) count = count - 32'd1;
        last_pins = pins;
      end
      qcs_pkg::ReqSample: begin
        elapsed = w.now_ms - ref_time;
        period  = (period_ms == 16'd0) ? 32'd1 : {16'd0, period_ms};
        if (elapsed >= period) begin
          if (metres_per_cnt != 24'd0 && elapsed <= qcs_pkg::MaxElapsedMs) begin
            speed_q    = speed_of(elapsed);
            speed_good = 1'b1;
          end else begin
            speed_q    = '0;
            speed_good = 1'b0;
          end
          ref_count = count;
          ref_time  = w.now_ms;
          taken     = 1'b1;
        end
      end
      qcs_pkg::ReqStart: begin
        last_pins  = pins;
        ref_time   = w.now_ms;
        speed_q    = '0;
        speed_good = 1'b0;
      end
      default: ;
    endcase
    exp.position     = count;
    exp.speed        = speed_good ? speed_q : 32'd0;
    exp.speed_valid  = speed_good;
    exp.sample_taken = taken;
    due_readings.push_back(exp);
  endfunction

  task report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(input enc_reading_t got);
    enc_reading_t exp;
    if (due_readings.size() == 0) begin
      report("result word with no word pending");
    end else begin
      exp = due_readings.pop_front();
      if (got.position !== exp.position)
        report($sformatf("position got %0d want %0d", got.position, exp.position));
      if (got.speed !== exp.speed)
        report($sformatf("speed got %0d want %0d", got.speed, exp.speed));
      if (got.speed_valid !== exp.speed_valid)
        report($sformatf("speed_valid got %b want %b", got.speed_valid, exp.speed_valid));
      if (got.sample_taken !== exp.sample_taken)
        report($sformatf("sample_taken got %b want %b", got.sample_taken, exp.sample_taken));
    end
  endtask

  function int outstanding();
    return due_readings.size();
  endfunction
endclass

module testbench;
  import qcs_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  qcs_req_if req_bus();
  qcs_res_if res_bus();

  quadrature_counter_with_speed i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .res_o       (res_bus)
  );

  speed_tracker tracker = new();
  bit           burst;
  logic [1:0]   enc_pos;
  logic [31:0]  clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic enc_word_t mk_word(input logic [1:0] req, input logic [1:0] pins,
                                        input logic [31:0] now);
    enc_word_t w;
    w.req_type = req;
    w.pin_a    = pins[1];
    w.pin_b    = pins[0];
    w.now_ms   = now;
    return w;
  endfunction

  // quadrature phase to pin levels {a, b}
  function automatic logic [1:0] gray_pins(input logic [1:0] ph);
    logic [1:0] p;
    case (ph)
      2'd0: p = 2'b00;
      2'd1: p = 2'b01;
      2'd2: p = 2'b11;
      default: p = 2'b10;
    endcase
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task send_word(input enc_word_t w);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.req_type = w.req_type;
    req_bus.pin_a    = w.pin_a;
    req_bus.pin_b    = w.pin_b;
    req_bus.now_ms   = w.now_ms;
    req_bus.valid    = 1'b1;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    tracker.take_word(w);
    @(negedge clk_i);
  endtask

  task step_pins(input logic [1:0] delta);
    enc_pos = enc_pos + delta;
    send_word(mk_word(ReqPin, gray_pins(enc_pos), $urandom));
  endtask

  task sample_at(input logic [31:0] now);
    clock_ms = now;
    send_word(mk_word(ReqSample, 2'($urandom), now));
  endtask

  task drain_results();
    req_bus.valid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // result side
  initial begin
    int unsigned  stall;
    enc_reading_t got;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        res_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_bus.ready = 1'b1;
      @(posedge clk_i);
      while (!res_bus.valid) @(posedge clk_i);
      got.position     = res_bus.position;
      got.speed        = res_bus.speed;
      got.speed_valid  = res_bus.speed_valid;
      got.sample_taken = res_bus.sample_taken;
      tracker.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned guard;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_wdata_i      = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = '0;
    req_bus.pin_a    = 1'b0;
    req_bus.pin_b    = 1'b0;
    req_bus.now_ms   = '0;
    burst            = 1'b0;
    enc_pos          = 2'd0;
    clock_ms         = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults: sample with zero scale is taken but invalid
    sample_at(32'd10);
    send_word(mk_word(ReqUnused, 2'b11, 32'hFFFF_FFFF));
    drain_results();

    // zero period, full scale
    set_reg(CfgSamplePeriod, 24'd0);
    set_reg(CfgMetresPerCount, 24'hFF_FFFF);
    set_reg(CfgCountDirection, 24'd0);
    enc_pos = 2'd0;
    send_word(mk_word(ReqStart, 2'b00, 32'hFFFF_FFF0));
    repeat (4) step_pins(2'd1);
    // zero elapsed never samples, then a short valid one
    sample_at(32'hFFFF_FFF0);
    sample_at(32'hFFFF_FFF3);
    repeat (5) step_pins(2'd3);
    // double transitions and an unchanged pair
    step_pins(2'd2);
    step_pins(2'd2);
    step_pins(2'd0);
    step_pins(2'd2);
    // elapsed across the time wrap, then beyond the speed window
    sample_at(32'h0000_0010);
    sample_at(32'h0000_0100);
    drain_results();

    set_reg(CfgCountDirection, 24'd1);
    step_pins(2'd1);
    step_pins(2'd1);
    sample_at(32'h0000_0105);
    send_word(mk_word(ReqStart, gray_pins(enc_pos), 32'h0000_0106));

    for (int ph = 0; ph < 8; ph++) begin
      logic [15:0] per;
      logic [23:0] mpc;
      logic        dir;
      int unsigned fwd_pct;
      int unsigned smp_pct;
      case (ph)
        0: begin per = 16'd1;     mpc = 24'hFF_FFFF; dir = 1'b0; fwd_pct = 95; smp_pct = 3;  end
        1: begin per = 16'd10;    mpc = 24'd1;       dir = 1'b1; fwd_pct = 50; smp_pct = 20; end
        2: begin per = 16'hFFFF;  mpc = 24'($urandom); dir = 1'b0; fwd_pct = 60; smp_pct = 15; end
        3: begin per = 16'd5;     mpc = 24'd0;       dir = 1'b1; fwd_pct = 50; smp_pct = 20; end
        4: begin per = 16'd1;     mpc = 24'hFF_FFFF; dir = 1'b1; fwd_pct = 5;  smp_pct = 4;  end
        default: begin
          per     = 16'($urandom_range(0, 120));
          mpc     = 24'($urandom);
          dir     = 1'($urandom);
          fwd_pct = $urandom_range(0, 100);
          smp_pct = $urandom_range(5, 30);
        end
      endcase
      drain_results();
      burst = (ph == 5);
      set_reg(CfgSamplePeriod, {8'($urandom), per});
      set_reg(CfgMetresPerCount, mpc);
      set_reg(CfgCountDirection, {23'($urandom), dir});
      send_word(mk_word(ReqStart, gray_pins(enc_pos), clock_ms));

      for (int n = 0; n < 160; n++) begin
        int unsigned r;
        int unsigned c;
        if (ph == 6 && n == 80) drain_results();
        r = $urandom_range(0, 99);
        if (r < smp_pct) begin
          c = $urandom_range(0, 9);
          case (c)
            0: sample_at(clock_ms);
            1, 2: sample_at(clock_ms + $urandom_range(1, 3));
            7: sample_at(clock_ms + $urandom_range(101, 80000));
            8: sample_at($urandom);
            9: sample_at(clock_ms + {16'd0, per} + $urandom_range(0, 5));
            default: sample_at(clock_ms + $urandom_range(1, 110));
          endcase
        end else if (r < smp_pct + 2) begin
          clock_ms = clock_ms + $urandom_range(0, 20);
          send_word(mk_word(ReqStart, gray_pins(enc_pos), clock_ms));
        end else if (r < smp_pct + 4) begin
          // noise: unused code or a random pin pair
          if ($urandom_range(0, 1) == 0) begin
            send_word(mk_word(ReqUnused, 2'($urandom), $urandom));
          end else begin
            enc_pos = 2'($urandom);
            send_word(mk_word(ReqPin, gray_pins(enc_pos), $urandom));
          end
        end else begin
          c = $urandom_range(0, 19);
          if (c == 0) step_pins(2'd0);
          else if (c == 1) step_pins(2'd2);
          else if ($urandom_range(0, 99) < fwd_pct) step_pins(2'd1);
          else step_pins(2'd3);
        end
      end
    end

    req_bus.valid = 1'b0;
    burst = 1'b0;
    guard = 0;
    while (tracker.outstanding() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (40) @(negedge clk_i);
    if (tracker.outstanding() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.outstanding()));
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
